>>> src/if2i8_pkg.sv
// ----------------------------------------------------------------------------
// if2i8_pkg: shared types and constants
// float sample to int8 converter: register indexes, widths, result struct
// ----------------------------------------------------------------------------
package if2i8_pkg;

  localparam int MaxChannels = 16;
  localparam int ChanLimit   = (MaxChannels < 16) ? MaxChannels : 16;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_FORMAT = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] sample_value;
    logic        [3:0] channel_index;
    logic              clipped;
  } result_t;

endpackage

>>> src/if2i8_if.sv
// ----------------------------------------------------------------------------
// if2i8_in_if / if2i8_out_if: valid/ready channels
// input carries the raw ieee word, output the converted sample
// ----------------------------------------------------------------------------
interface if2i8_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_bits;
  modport source (output valid, output sample_bits, input ready);
  modport sink   (input valid, input sample_bits, output ready);
endinterface

interface if2i8_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample_value;
  logic        [3:0] channel_index;
  logic              clipped;
  modport source (output valid, output sample_value, output channel_index,
                  output clipped, input ready);
  modport sink   (input valid, input sample_value, input channel_index,
                  input clipped, output ready);
endinterface

>>> src/if2i8_decode.sv
// ----------------------------------------------------------------------------
// if2i8_decode: ieee special cases and int8 saturation
// picks zero, nan, infinity or the clipped magnitude from the exact path
// ----------------------------------------------------------------------------
module if2i8_decode (
  input  logic              fmt_dbl,
  input  logic [63:0]       bits,
  input  logic [8:0]        mag,
  input  logic              big,
  output logic signed [7:0] value,
  output logic              clip
);
  logic neg;
  logic ex_max;
  logic ex_zero;
  logic man_nz;

  always_comb begin
    if (fmt_dbl) begin
      neg     = bits[63];
      ex_max  = &bits[62:52];
      ex_zero = ~|bits[62:52];
      man_nz  = |bits[51:0];
    end else begin
      neg     = bits[31];
      ex_max  = &bits[30:23];
      ex_zero = ~|bits[30:23];
      man_nz  = |bits[22:0];
    end
    value = 8'sd0;
    clip  = 1'b0;
    // nan stays zero, infinity saturates by sign, zero/denormal give zero
    if (ex_max) begin
      if (!man_nz) begin
        value = neg ? -8'sd128 : 8'sd127;
        clip  = 1'b1;
      end
    end else if (!ex_zero) begin
      if (!neg) begin
        if (big || mag > 9'd127) begin
          value = 8'sd127;
          clip  = 1'b1;
        end else begin
          value = $signed(mag[7:0]);
        end
      end else begin
        if (big || mag > 9'd128) begin
          value = -8'sd128;
          clip  = 1'b1;
        end else begin
          value = 8'(-$signed({1'b0, mag}));
        end
      end
    end
  end
endmodule

>>> src/if2i8_exact.sv
// ----------------------------------------------------------------------------
// if2i8_exact: exact truncated magnitude of sig*127*2^e for e in -8..0
// uses the full 53-bit significand so floor is bit exact for both formats
// ----------------------------------------------------------------------------
module if2i8_exact (
  input  logic        fmt_dbl,
  input  logic [63:0] bits,
  output logic [8:0]  mag,
  output logic        big
);
  // 1.m aligned to 52 fraction bits; float32 mantissa padded on the right
  logic [52:0] sig;
  logic [59:0] prod;  // sig*127 as (sig<<7)-sig
  logic signed [12:0] e;
  logic        in_win;
  logic [3:0]  sh;
  logic [59:0] shd;

  always_comb begin
    if (fmt_dbl) begin
      sig = {1'b1, bits[51:0]};
      e   = $signed({2'b00, bits[62:52]}) - 13'sd1023;
    end else begin
      sig = {1'b1, bits[22:0], 29'd0};
      e   = $signed({5'b00000, bits[30:23]}) - 13'sd127;
    end
    prod   = {sig, 7'd0} - {7'd0, sig};
    // e >= 1 means |x| >= 2, always saturates; e <= -8 gives zero
    big    = (e >= 13'sd1);
    in_win = !big && (e > -13'sd9);
    sh     = in_win ? 4'(-e) : 4'd0;
    shd    = prod >> (6'd52 + {2'b00, sh});
    mag    = in_win ? shd[8:0] : 9'd0;
  end
endmodule

>>> src/ieee_float_to_int8_sample_top.sv
// ----------------------------------------------------------------------------
// ieee_float_to_int8_sample_top: ieee float sample to int8 converter
// decodes float32/float64 samples to saturated int8 and tags channel
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  in_     | in  | sample_bits[63:0]                         | valid/ready
//  out_    | out | sample_value[7:0], channel_index, clipped | valid/ready
//  cfg_    | in  | cfg_index, cfg_data                       | cfg_we
//
// one transaction per cycle unless out_ready stalls a full result register; input goes straight to the result register
// decode is one pass of logic: exponent select, multiply by 127, shift, clip
// synchronous active-low reset clears output valid and channel position, sets config to float32, one channel
// in_ready is high whenever the result register is empty or being drained
module ieee_float_to_int8_sample_top (
  input  logic clk,
  input  logic rst_n,
  if2i8_in_if.sink    in_ch,
  if2i8_out_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [if2i8_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [if2i8_pkg::CfgDataW-1:0] cfg_data
);
  import if2i8_pkg::*;

  logic       fmt_r;
  logic [4:0] count_r;
  logic [3:0] pos_r, pos_nxt;
  logic       valid_r;
  result_t    res_r, res_nxt;
  logic       accept;
  logic [4:0] eff;
  logic [8:0] mag;
  logic       big;
  logic signed [7:0] dec_value;
  logic       dec_clip;

  // exact magnitude path
  if2i8_exact u_exact (
    .fmt_dbl (fmt_r),
    .bits    (in_ch.sample_bits),
    .mag     (mag),
    .big     (big)
  );

  // special cases and saturation
  if2i8_decode u_decode (
    .fmt_dbl (fmt_r),
    .bits    (in_ch.sample_bits),
    .mag     (mag),
    .big     (big),
    .value   (dec_value),
    .clip    (dec_clip)
  );

  assign in_ch.ready = !valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // effective channel count: zero acts as one, clamp to limit
  always_comb begin
    eff = count_r;
    if (eff == 5'd0) eff = 5'd1;
    if (eff > 5'(ChanLimit)) eff = 5'(ChanLimit);
    pos_nxt = ({1'b0, pos_r} + 5'd1 >= eff) ? 4'd0 : pos_r + 4'd1;
  end

  // result tagged with the current channel position
  always_comb begin
    res_nxt.sample_value  = dec_value;
    res_nxt.channel_index = pos_r;
    res_nxt.clipped       = dec_clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      count_r <= 5'd1;
      pos_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SAMPLE_FORMAT: fmt_r   <= cfg_data[0];
          REG_CHANNEL_COUNT: count_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        valid_r <= 1'b1;
        pos_r   <= pos_nxt;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.sample_value  = res_r.sample_value;
  assign out_ch.channel_index = res_r.channel_index;
  assign out_ch.clipped       = res_r.clipped;
endmodule

>>> src/if2i8_checker.sv
// ----------------------------------------------------------------------------
// if2i8_checker: port-level assertions
// output value/clip consistency and stall behavior
// ----------------------------------------------------------------------------
module if2i8_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_value,
  input logic        [3:0] out_chan,
  input logic              out_clip
);
  a_clip_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clip |-> out_value == 8'sd127 || out_value == -8'sd128)
    else $error("clipped result not at range edge");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chan))
    else $error("stalled result changed");
endmodule

bind ieee_float_to_int8_sample_top if2i8_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.sample_value),
  .out_chan  (out_ch.channel_index),
  .out_clip  (out_ch.clipped)
);
